/* rtl/mtep_pkg.sv */
// shared types and constants of the midi track event parser
package mtep_pkg;

  localparam int TrackCountDef = 32;
  localparam int InDataW       = 16;
  localparam int OutDataW      = 88;

  localparam logic [7:0] SysexStart  = 8'hF0;
  localparam logic [7:0] SysexEscape = 8'hF7;
  localparam logic [7:0] MetaStatus  = 8'hFF;
  localparam logic [7:0] MetaEnd     = 8'h2F;
  localparam logic [7:0] MetaTempo   = 8'h51;

  localparam logic [2:0] ClassProgram  = 3'd4;
  localparam logic [2:0] ClassPressure = 3'd5;
  localparam logic [2:0] ClassSystem   = 3'd7;

  typedef enum logic [3:0] {
    PH_DELTA    = 4'd0,
    PH_STATUS   = 4'd1,
    PH_DATA1    = 4'd2,
    PH_DATA2    = 4'd3,
    PH_SYSLEN   = 4'd4,
    PH_SKIP     = 4'd5,
    PH_METATYPE = 4'd6,
    PH_METALEN  = 4'd7,
    PH_TEMPO0   = 4'd8,
    PH_TEMPO1   = 4'd9,
    PH_TEMPO2   = 4'd10
  } phase_e;

  typedef enum logic [1:0] {
    KIND_SHORT = 2'd0,
    KIND_TEMPO = 2'd1,
    KIND_END   = 2'd2
  } event_kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       track_start;
    logic [4:0] track_id;
  } in_item_t;

  typedef struct packed {
    logic [31:0] event_time;
    event_kind_e event_kind;
    logic [7:0]  status_out;
    logic [6:0]  first_data;
    logic [6:0]  second_data;
    logic [23:0] tempo_value;
    logic [4:0]  source_track;
  } result_t;

  // control between the stages
  typedef struct packed {
    logic item_valid;
    logic out_ready;
    logic take;
  } stage_ctl_t;

endpackage

/* rtl/mtep_in_reg.sv */
// input register of the parser: holds one item until the core takes it
module mtep_in_reg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_tvalid_i,
  output logic                        s_tready_o,
  input  logic [mtep_pkg::InDataW-1:0] s_tdata_i,
  input  logic                        s_tuser_i,
  input  logic                        take_i,
  output logic                        item_valid_o,
  output mtep_pkg::in_item_t          item_o
);
  import mtep_pkg::*;

  logic     valid_q, valid_d;
  in_item_t item_q;
  logic     fire;

  assign s_tready_o = !valid_q || take_i;
  assign fire       = s_tvalid_i && s_tready_o;

  always_comb begin
    valid_d = valid_q;
    if (fire) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      item_q.data_byte   <= s_tdata_i[7:0];
      item_q.track_id    <= s_tdata_i[12:8];
      item_q.track_start <= s_tuser_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

/* rtl/mtep_core.sv */
// parse state and per-byte next-state and result logic
module mtep_core #(
  parameter int TRACK_COUNT = mtep_pkg::TrackCountDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 take_i,
  input  mtep_pkg::in_item_t   item_i,
  output logic                 res_valid_o,
  output mtep_pkg::result_t    result_o
);
  import mtep_pkg::*;

  phase_e      phase_q, phase_d;
  logic [31:0] tick_q, tick_d;
  logic [31:0] acc_q, acc_d;
  logic [2:0]  class_q, class_d;
  logic [3:0]  chan_q, chan_d;
  logic [6:0]  held_q, held_d;
  logic [7:0]  meta_q, meta_d;
  logic [23:0] tempo_q, tempo_d;
  logic [31:0] skip_q, skip_d;
  logic        done_q, done_d;

  logic [7:0]  b;
  logic [31:0] acc_next;
  logic        in_range;

  assign b        = item_i.data_byte;
  assign in_range = {4'd0, item_i.track_id} < 9'(TRACK_COUNT);

  always_comb begin
    phase_d = phase_q;
    tick_d  = tick_q;
    acc_d   = acc_q;
    class_d = class_q;
    chan_d  = chan_q;
    held_d  = held_q;
    meta_d  = meta_q;
    tempo_d = tempo_q;
    skip_d  = skip_q;
    done_d  = done_q;
    res_valid_o = 1'b0;
    result_o.event_time   = 32'd0;
    result_o.event_kind   = KIND_SHORT;
    result_o.status_out   = 8'd0;
    result_o.first_data   = 7'd0;
    result_o.second_data  = 7'd0;
    result_o.tempo_value  = 24'd0;
    result_o.source_track = item_i.track_id;
    acc_next = 32'd0;

    if (in_range) begin
      if (item_i.track_start) begin
        phase_d = PH_DELTA;
        tick_d  = 32'd0;
        acc_d   = 32'd0;
        class_d = 3'd0;
        chan_d  = 4'd0;
        held_d  = 7'd0;
        skip_d  = 32'd0;
        done_d  = 1'b0;
      end
      // shifted accumulator: low seven bits are free, so no adder
      acc_next = {acc_d[24:0], b[6:0]};
      result_o.event_time = tick_d;
      if (!done_d) begin
        case (phase_d)
          PH_DELTA: begin
            acc_d = acc_next;
            if (!b[7]) begin
              tick_d  = tick_d + acc_next;
              acc_d   = 32'd0;
              phase_d = PH_STATUS;
            end
          end
          PH_STATUS, PH_DATA1: begin
            if (phase_d == PH_STATUS && (b == SysexStart || b == SysexEscape)) begin
              phase_d = PH_SYSLEN;
            end else if (phase_d == PH_STATUS && b == MetaStatus) begin
              phase_d = PH_METATYPE;
            end else if (phase_d == PH_STATUS && b[7]) begin
              chan_d  = b[3:0];
              class_d = b[6:4];
              phase_d = PH_DATA1;
            end else if (class_d == ClassProgram || class_d == ClassPressure) begin
              res_valid_o         = 1'b1;
              result_o.status_out = {1'b1, class_d, chan_d};
              result_o.first_data = b[6:0];
              phase_d             = PH_DELTA;
            end else if (class_d == ClassSystem) begin
              phase_d = PH_DELTA;
            end else begin
              held_d  = b[6:0];
              phase_d = PH_DATA2;
            end
          end
          PH_DATA2: begin
            res_valid_o          = 1'b1;
            result_o.status_out  = {1'b1, class_d, chan_d};
            result_o.first_data  = held_d;
            result_o.second_data = b[6:0];
            phase_d              = PH_DELTA;
          end
          PH_SYSLEN: begin
            acc_d = acc_next;
            if (!b[7]) begin
              acc_d   = 32'd0;
              skip_d  = acc_next;
              phase_d = (acc_next != 32'd0) ? PH_SKIP : PH_DELTA;
            end
          end
          PH_SKIP: begin
            skip_d = skip_d - 32'd1;
            if (skip_d == 32'd0) begin
              phase_d = PH_DELTA;
            end
          end
          PH_METATYPE: begin
            meta_d  = b;
            phase_d = PH_METALEN;
          end
          PH_METALEN: begin
            acc_d = acc_next;
            if (!b[7]) begin
              acc_d = 32'd0;
              if (meta_d == MetaEnd) begin
                done_d              = 1'b1;
                phase_d             = PH_DELTA;
                res_valid_o         = 1'b1;
                result_o.event_kind = KIND_END;
              end else if (meta_d == MetaTempo) begin
                tempo_d = 24'd0;
                phase_d = PH_TEMPO0;
              end else begin
                skip_d  = acc_next;
                phase_d = (acc_next != 32'd0) ? PH_SKIP : PH_DELTA;
              end
            end
          end
          PH_TEMPO0: begin
            tempo_d = {tempo_d[15:0], b};
            phase_d = PH_TEMPO1;
          end
          PH_TEMPO1: begin
            tempo_d = {tempo_d[15:0], b};
            phase_d = PH_TEMPO2;
          end
          PH_TEMPO2: begin
            tempo_d              = {tempo_d[15:0], b};
            phase_d              = PH_DELTA;
            res_valid_o          = 1'b1;
            result_o.event_kind  = KIND_TEMPO;
            result_o.tempo_value = tempo_d;
          end
          default: begin
            phase_d = PH_DELTA;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_DELTA;
      tick_q  <= 32'd0;
      acc_q   <= 32'd0;
      class_q <= 3'd0;
      chan_q  <= 4'd0;
      held_q  <= 7'd0;
      meta_q  <= 8'd0;
      tempo_q <= 24'd0;
      skip_q  <= 32'd0;
      done_q  <= 1'b0;
    end else if (take_i) begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      acc_q   <= acc_d;
      class_q <= class_d;
      chan_q  <= chan_d;
      held_q  <= held_d;
      meta_q  <= meta_d;
      tempo_q <= tempo_d;
      skip_q  <= skip_d;
      done_q  <= done_d;
    end
  end

endmodule

/* rtl/mtep_out_reg.sv */
// result register of the parser, drives the master-side stream
module mtep_out_reg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          load_i,
  input  logic                          res_valid_i,
  input  mtep_pkg::result_t             result_i,
  output logic                          out_ready_o,
  output logic                          m_tvalid_o,
  input  logic                          m_tready_i,
  output logic [mtep_pkg::OutDataW-1:0] m_tdata_o,
  output logic [1:0]                    m_tuser_o
);
  import mtep_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  assign out_ready_o = !valid_q || m_tready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = res_valid_i;
    end else if (m_tready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && res_valid_i) begin
      res_q <= result_i;
    end
  end

  assign m_tvalid_o = valid_q;
  assign m_tdata_o  = {5'd0, res_q.source_track, res_q.tempo_value, res_q.second_data,
                       res_q.first_data, res_q.status_out, res_q.event_time};
  assign m_tuser_o  = res_q.event_kind;

endmodule

/* rtl/midi_track_event_parser.sv */
// top level of the midi track event parser
// Parses the bytes of a standard midi file track chunk, one byte per item.
// Input stream: s_tdata carries the raw byte and the track number, s_tuser
// flags the first byte of a track, which clears time, running status and the
// end-of-track flag. Bytes of a track number at or above TRACK_COUNT are
// dropped without effect.
// Output stream: one item per channel message, tempo meta or end of track,
// with the absolute tick time; m_tuser carries the event kind.
// An input item is registered in the input register and parsed when the core
// takes it; the result register then holds its result for the master side.
// Throughput: one byte per cycle unless the receiver stalls; the byte parse
// is a single pass of logic between the input and the result register.
// Reset clears the parse state and empties both registers.
// When the receiver stalls, the result register holds its item, the input
// register keeps one more byte, and s_tready falls until m_tready returns.
module midi_track_event_parser #(
  parameter int TRACK_COUNT = mtep_pkg::TrackCountDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_tvalid_i,
  output logic                          s_tready_o,
  // [7:0] data_byte, [12:8] track_id, zero fill above
  input  logic [mtep_pkg::InDataW-1:0]  s_tdata_i,
  // [0] track_start
  input  logic                          s_tuser_i,
  output logic                          m_tvalid_o,
  input  logic                          m_tready_i,
  // [31:0] event_time, [39:32] status_out, [46:40] first_data,
  // [53:47] second_data, [77:54] tempo_value, [82:78] source_track, zero fill
  output logic [mtep_pkg::OutDataW-1:0] m_tdata_o,
  // [1:0] event_kind
  output logic [1:0]                    m_tuser_o
);
  import mtep_pkg::*;

  stage_ctl_t ctl;
  in_item_t   item;
  result_t    result;
  logic       res_valid;

  assign ctl.take = ctl.item_valid && ctl.out_ready;

  mtep_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_tvalid_i),
    .s_tready_o   (s_tready_o),
    .s_tdata_i    (s_tdata_i),
    .s_tuser_i    (s_tuser_i),
    .take_i       (ctl.take),
    .item_valid_o (ctl.item_valid),
    .item_o       (item)
  );

  mtep_core #(
    .TRACK_COUNT (TRACK_COUNT)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (ctl.take),
    .item_i      (item),
    .res_valid_o (res_valid),
    .result_o    (result)
  );

  mtep_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (ctl.take),
    .res_valid_i (res_valid),
    .result_i    (result),
    .out_ready_o (ctl.out_ready),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_o   (m_tdata_o),
    .m_tuser_o   (m_tuser_o)
  );

endmodule
